// ===== rtl/cll_pkg.sv =====
// Shared constants, microcode types and control structs for the linked-list block.
`default_nettype none

package cll_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int POS_W        = 10;
  localparam int NUM_W        = 32;
  localparam int NAME_W       = 64;
  localparam int STATUS_W     = 2;
  localparam int STEP_W       = 4;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Datapath operations, one per microcode step.
  typedef enum logic [3:0] {
    A_NONE,
    A_INS_SETUP,
    A_WALK,
    A_LINK_RD,
    A_LINK_NEW,
    A_LINK_PREV,
    A_HEAD_INS,
    A_INS_DONE,
    A_FULL_DONE,
    A_RD_SETUP,
    A_REC_RD,
    A_RD_DONE,
    A_BAD_DONE
  } act_t;

  // Jump conditions tested by the sequencer.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOSTART,
    C_READ,
    C_FULL,
    C_HEAD,
    C_HOPS,
    C_RDBAD
  } cond_t;

  typedef struct packed {
    act_t              act;
    cond_t             cond;
    logic [STEP_W-1:0] target;
    logic              needs_out;
  } uword_t;

  typedef struct packed {
    act_t act;
    logic idle;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic is_read;
    logic full;
    logic head_case;
    logic hops_nz;
    logic rd_bad;
    logic out_busy;
  } flags_t;

endpackage

`default_nettype wire

// ===== rtl/cll_req_if.sv =====
// Request channel: valid/ready handshake with the insert or read item.
`default_nettype none

interface cll_req_if;
  import cll_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [POS_W-1:0]         position;
  logic signed [NUM_W-1:0]  record_number;
  logic [NAME_W-1:0]        name_tag;

  modport source (output valid, mode, position, record_number, name_tag, input ready);
  modport sink   (input valid, mode, position, record_number, name_tag, output ready);
endinterface

`default_nettype wire

// ===== rtl/cll_rsp_if.sv =====
// Response channel: valid/ready handshake with the result of one item.
`default_nettype none

interface cll_rsp_if;
  import cll_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [POS_W-1:0]         slot;
  logic [POS_W-1:0]         final_position;
  logic signed [NUM_W-1:0]  read_number;
  logic [NAME_W-1:0]        read_name;

  modport source (output valid, status, slot, final_position, read_number, read_name,
                  input ready);
  modport sink   (input valid, status, slot, final_position, read_number, read_name,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/cursor_linked_list_insert.sv =====
// Top level: array-cursor singly linked list with insert and read by position.
// Insert at head links the new node directly; an insert after k hops (k = min(position-1,
//   length-1)) walks the list and relinks; a read at position p walks p hops; full or
//   out-of-range items finish without a walk. Throughput: one item at a time, the next
//   accepted in the idle step after the result is loaded; one link-memory read per walk cycle.
// Reset: synchronous rst clears the slot count, head and result valid; the node
//   memories are not cleared, every walk stays within the written length.
`default_nettype none

module cursor_linked_list_insert #(
  parameter int CAPACITY = cll_pkg::CAPACITY_DEF
) (
  input wire        clk,
  input wire        rst,
  cll_req_if.sink   req,
  cll_rsp_if.source rsp
);
  import cll_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;

  // Take a new request beat only while the sequencer waits in its idle step;
  // a finished result may still sit in the output register.
  assign req.ready = ctrl.idle;

  // Sequencer: walks the microprogram, branching on datapath flags.
  cll_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // Datapath: node memories, list walk and the result beat register.
  cll_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .flags (flags),
    .req   (req),
    .rsp   (rsp)
  );

endmodule

`default_nettype wire

// ===== rtl/cll_seq.sv =====
// Microcode sequencer: step counter, control-word ROM and conditional jumps.
`default_nettype none

module cll_seq (
  input  wire             clk,
  input  wire             rst,
  input  cll_pkg::flags_t flags,
  output cll_pkg::ctrl_t  ctrl
);
  import cll_pkg::*;

  localparam logic [STEP_W-1:0] S_IDLE     = STEP_W'(0);
  localparam logic [STEP_W-1:0] S_DISPATCH = STEP_W'(1);
  localparam logic [STEP_W-1:0] S_CHKFULL  = STEP_W'(2);
  localparam logic [STEP_W-1:0] S_SETUP    = STEP_W'(3);
  localparam logic [STEP_W-1:0] S_IWALK    = STEP_W'(4);
  localparam logic [STEP_W-1:0] S_LRD      = STEP_W'(5);
  localparam logic [STEP_W-1:0] S_LNEW     = STEP_W'(6);
  localparam logic [STEP_W-1:0] S_LPREV    = STEP_W'(7);
  localparam logic [STEP_W-1:0] S_HEAD     = STEP_W'(8);
  localparam logic [STEP_W-1:0] S_IDONE    = STEP_W'(9);
  localparam logic [STEP_W-1:0] S_FDONE    = STEP_W'(10);
  localparam logic [STEP_W-1:0] S_RSETUP   = STEP_W'(11);
  localparam logic [STEP_W-1:0] S_RWALK    = STEP_W'(12);
  localparam logic [STEP_W-1:0] S_RREC     = STEP_W'(13);
  localparam logic [STEP_W-1:0] S_RDONE    = STEP_W'(14);
  localparam logic [STEP_W-1:0] S_BDONE    = STEP_W'(15);

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{A_NONE, C_NEVER, S_IDLE, 1'b0};
    case (step)
      S_IDLE:     w = '{A_NONE,      C_NOSTART, S_IDLE,   1'b0};
      S_DISPATCH: w = '{A_NONE,      C_READ,    S_RSETUP, 1'b0};
      S_CHKFULL:  w = '{A_NONE,      C_FULL,    S_FDONE,  1'b0};
      S_SETUP:    w = '{A_INS_SETUP, C_HEAD,    S_HEAD,   1'b0};
      S_IWALK:    w = '{A_WALK,      C_HOPS,    S_IWALK,  1'b0};
      S_LRD:      w = '{A_LINK_RD,   C_NEVER,   S_IDLE,   1'b0};
      S_LNEW:     w = '{A_LINK_NEW,  C_NEVER,   S_IDLE,   1'b0};
      S_LPREV:    w = '{A_LINK_PREV, C_ALWAYS,  S_IDONE,  1'b0};
      S_HEAD:     w = '{A_HEAD_INS,  C_NEVER,   S_IDLE,   1'b0};
      S_IDONE:    w = '{A_INS_DONE,  C_ALWAYS,  S_IDLE,   1'b1};
      S_FDONE:    w = '{A_FULL_DONE, C_ALWAYS,  S_IDLE,   1'b1};
      S_RSETUP:   w = '{A_RD_SETUP,  C_RDBAD,   S_BDONE,  1'b0};
      S_RWALK:    w = '{A_WALK,      C_HOPS,    S_RWALK,  1'b0};
      S_RREC:     w = '{A_REC_RD,    C_NEVER,   S_IDLE,   1'b0};
      S_RDONE:    w = '{A_RD_DONE,   C_ALWAYS,  S_IDLE,   1'b1};
      S_BDONE:    w = '{A_BAD_DONE,  C_ALWAYS,  S_IDLE,   1'b1};
      default:    w = '{A_NONE,      C_ALWAYS,  S_IDLE,   1'b0};
    endcase
    return w;
  endfunction

  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  uword_t            uw;
  logic              stall;
  logic              taken;

  assign uw    = ucode(pc);
  // Hold a result step until the output register is free.
  assign stall = uw.needs_out & flags.out_busy;

  always_comb begin
    case (uw.cond)
      C_NEVER:   taken = 1'b0;
      C_ALWAYS:  taken = 1'b1;
      C_NOSTART: taken = ~flags.start;
      C_READ:    taken = flags.is_read;
      C_FULL:    taken = flags.full;
      C_HEAD:    taken = flags.head_case;
      C_HOPS:    taken = flags.hops_nz;
      C_RDBAD:   taken = flags.rd_bad;
      default:   taken = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      pc_next = pc;
    end else if (taken) begin
      pc_next = uw.target;
    end else begin
      pc_next = pc + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign ctrl.act  = stall ? A_NONE : uw.act;
  assign ctrl.idle = (pc == S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/cll_dp.sv =====
// Datapath: node memories, walk pointer, counters and the result register.
`default_nettype none

module cll_dp #(
  parameter int CAPACITY = cll_pkg::CAPACITY_DEF
) (
  input  wire             clk,
  input  wire             rst,
  input  cll_pkg::ctrl_t  ctrl,
  output cll_pkg::flags_t flags,
  cll_req_if.sink         req,
  cll_rsp_if.source       rsp
);
  import cll_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  // Node memories
  logic [NUM_W-1:0]  num_mem  [CAPACITY];
  logic [NAME_W-1:0] name_mem [CAPACITY];
  logic [AW-1:0]     link_mem [CAPACITY];

  // Latched request
  logic              mode_r;
  logic [POS_W-1:0]  pos_r;
  logic [NUM_W-1:0]  num_r;
  logic [NAME_W-1:0] name_r;

  // List state and walk registers
  logic [CW-1:0]     count;
  logic [AW-1:0]     head;
  logic [AW-1:0]     cur;
  logic              chain;
  logic [POS_W-1:0]  hops;
  logic [POS_W-1:0]  fpos;

  logic [AW-1:0]     link_rd;
  logic [NUM_W-1:0]  num_rd;
  logic [NAME_W-1:0] name_rd;

  // Result register
  logic              o_valid;
  logic [STATUS_W-1:0] o_status;
  logic [POS_W-1:0]  o_slot;
  logic [POS_W-1:0]  o_fpos;
  logic [NUM_W-1:0]  o_num;
  logic [NAME_W-1:0] o_name;
  logic              o_load;

  logic              take;
  logic [AW-1:0]     walk_ptr;
  logic [AW-1:0]     new_slot;
  logic [PW-1:0]     pos_m1_ext;
  logic [PW-1:0]     cnt_m1_ext;
  logic [PW-1:0]     k_ext;
  logic [POS_W-1:0]  k;
  logic [PW-1:0]     cnt_ext;
  logic [PW-1:0]     cur_ext;

  logic              link_we;
  logic [AW-1:0]     link_wa;
  logic [AW-1:0]     link_wd;
  logic              link_re;
  logic [AW-1:0]     link_ra;
  logic              rec_we;
  logic              rec_re;

  assign take     = ctrl.idle & req.valid;
  assign walk_ptr = chain ? link_rd : cur;
  assign new_slot = count[AW-1:0];

  // Predecessor hop count: min(position - 1, length - 1)
  assign pos_m1_ext = PW'(pos_r - POS_W'(1));
  assign cnt_m1_ext = PW'(count - CW'(1));
  assign k_ext      = (pos_m1_ext < cnt_m1_ext) ? pos_m1_ext : cnt_m1_ext;
  assign k          = k_ext[POS_W-1:0];
  assign cnt_ext    = PW'(count);
  assign cur_ext    = PW'(cur);

  // Any finishing step loads a new result beat.
  assign o_load = (ctrl.act == A_INS_DONE) || (ctrl.act == A_FULL_DONE) ||
                  (ctrl.act == A_RD_DONE) || (ctrl.act == A_BAD_DONE);

  assign flags.start     = req.valid;
  assign flags.is_read   = mode_r;
  assign flags.full      = (count == CW'(CAPACITY));
  assign flags.head_case = (count == '0) || (pos_r == '0);
  assign flags.hops_nz   = (hops != '0);
  assign flags.rd_bad    = (PW'(pos_r) >= cnt_ext);
  assign flags.out_busy  = o_valid & ~rsp.ready;

  always_comb begin
    link_we = 1'b0;
    link_wa = new_slot;
    link_wd = link_rd;
    link_re = 1'b0;
    link_ra = cur;
    rec_we  = 1'b0;
    rec_re  = 1'b0;
    case (ctrl.act)
      A_INS_SETUP: rec_we = 1'b1;
      A_WALK: begin
        link_re = flags.hops_nz;
        link_ra = walk_ptr;
      end
      A_LINK_RD:   link_re = 1'b1;
      A_LINK_NEW:  link_we = 1'b1;
      A_LINK_PREV: begin
        link_we = 1'b1;
        link_wa = cur;
        link_wd = new_slot;
      end
      A_HEAD_INS: begin
        link_we = 1'b1;
        link_wd = head;
      end
      A_REC_RD:    rec_re = 1'b1;
      default: begin
        link_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (link_re) begin
      link_rd <= link_mem[link_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      num_mem[new_slot]  <= num_r;
      name_mem[new_slot] <= name_r;
    end
    if (rec_re) begin
      num_rd  <= num_mem[cur];
      name_rd <= name_mem[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mode_r <= req.mode;
      pos_r  <= req.position;
      num_r  <= req.record_number;
      name_r <= req.name_tag;
    end
    case (ctrl.act)
      A_INS_SETUP: begin
        hops <= k;
        cur  <= head;
        fpos <= flags.head_case ? '0 : k + POS_W'(1);
      end
      A_RD_SETUP: begin
        hops <= pos_r;
        cur  <= head;
      end
      A_WALK: begin
        cur <= walk_ptr;
        if (flags.hops_nz) begin
          hops <= hops - POS_W'(1);
        end
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      head    <= '0;
      chain   <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
      case (ctrl.act)
        A_INS_SETUP, A_RD_SETUP: chain <= 1'b0;
        A_WALK:     chain <= flags.hops_nz;
        A_HEAD_INS: head  <= new_slot;
        A_INS_DONE: begin
          count    <= count + CW'(1);
          o_status <= ST_DONE;
          o_slot   <= cnt_ext[POS_W-1:0];
          o_fpos   <= fpos;
          o_num    <= '0;
          o_name   <= '0;
        end
        A_FULL_DONE: begin
          o_status <= ST_FULL;
          o_slot   <= '0;
          o_fpos   <= '0;
          o_num    <= '0;
          o_name   <= '0;
        end
        A_RD_DONE: begin
          o_status <= ST_DONE;
          o_slot   <= cur_ext[POS_W-1:0];
          o_fpos   <= pos_r;
          o_num    <= num_rd;
          o_name   <= name_rd;
        end
        A_BAD_DONE: begin
          o_status <= ST_RANGE;
          o_slot   <= '0;
          o_fpos   <= '0;
          o_num    <= '0;
          o_name   <= '0;
        end
        default: begin
          chain <= chain;
        end
      endcase
    end
  end

  assign rsp.valid          = o_valid;
  assign rsp.status         = o_status;
  assign rsp.slot           = o_slot;
  assign rsp.final_position = o_fpos;
  assign rsp.read_number    = o_num;
  assign rsp.read_name      = o_name;

endmodule

`default_nettype wire
